// File: hw/rtl/ssa_pkg.sv
`default_nettype none
package ssa_pkg;

   localparam int unsigned SLOT_W  = 5;
   localparam int unsigned PCT_W   = 11;
   localparam int unsigned TERM_W  = 16;
   localparam int unsigned SCALE_W = 9;
   localparam int unsigned MIN_W   = 7;
   localparam int unsigned FOOT_W  = 7;
   localparam int unsigned CSR_IDX_W = 2;

   localparam int unsigned UNITY_NUM   = 2560000;
   localparam int unsigned SHEAR_MUL   = 25600;
   localparam int unsigned PERCENT     = 100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBJECT_SCALE = 2'd0,
      CSR_MIN_SCALE    = 2'd1,
      CSR_FOOT_LINE    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic en;
      logic valid;
   } stage_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/ssa_pipe_div.sv
`default_nettype none
module ssa_pipe_div #(
   parameter int LANES = 1,
   parameter int NW    = 8,
   parameter int DW    = 8,
   parameter int SW    = 1
) (
   input  wire                           clock,
   input  wire                           reset,
   input  ssa_pkg::stage_ctl_type        in_ctl,
   input  wire  [LANES-1:0][NW:0]        in_num,
   input  wire  [LANES-1:0][DW:0]        in_den,
   input  wire  [SW-1:0]                 in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][NW:0]        out_quo,
   output logic [SW-1:0]                 out_side
);

   logic [NW:0]                         vld_ff, vld_in;
   logic [NW:0][SW-1:0]                 side_ff, side_in;
   logic [NW:0][LANES-1:0]              neg_ff, neg_in;
   logic [NW:0][LANES-1:0][NW-1:0]      num_ff, num_in;
   logic [NW:0][LANES-1:0][DW-1:0]      den_ff, den_in;
   logic [NW:0][LANES-1:0][DW-1:0]      rem_ff, rem_in;
   logic                                out_vld_ff;
   logic [LANES-1:0][NW:0]              quo_ff, quo_in;
   logic [SW-1:0]                       oside_ff;

   always_comb begin
      logic [NW:0] an;
      logic [DW:0] ad;
      logic [DW:0] trial;
      logic        ge;
      vld_in[0]  = in_ctl.valid;
      side_in[0] = in_side;
      for (int l = 0; l < LANES; l++) begin
         an = in_num[l][NW] ? (~in_num[l] + 1'b1) : in_num[l];
         ad = in_den[l][DW] ? (~in_den[l] + 1'b1) : in_den[l];
         num_in[0][l] = an[NW-1:0];
         den_in[0][l] = ad[DW-1:0];
         rem_in[0][l] = '0;
         neg_in[0][l] = in_num[l][NW] ^ in_den[l][DW];
      end
      for (int i = 0; i < NW; i++) begin
         vld_in[i+1]  = vld_ff[i];
         side_in[i+1] = side_ff[i];
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_ff[i][l], num_ff[i][l][NW-1]};
            ge    = trial >= {1'b0, den_ff[i][l]};
            rem_in[i+1][l] = ge ? DW'(trial - {1'b0, den_ff[i][l]}) : trial[DW-1:0];
            num_in[i+1][l] = {num_ff[i][l][NW-2:0], ge};
            den_in[i+1][l] = den_ff[i][l];
            neg_in[i+1][l] = neg_ff[i][l];
         end
      end
      for (int l = 0; l < LANES; l++) begin
         quo_in[l] = neg_ff[NW][l] ? (~{1'b0, num_ff[NW][l]} + 1'b1)
                                   : {1'b0, num_ff[NW][l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (in_ctl.en) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.en) begin
         side_ff  <= side_in;
         neg_ff   <= neg_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         oside_ff <= side_ff[NW];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_quo   = quo_ff;
   assign out_side  = oside_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sprite_shadow_affine_setup.sv
// sprite shadow affine setup
// req channel: one request per shadow sprite with slot, width and height scale
// percentages and the two shear amounts. rsp channel: one result per request
// with the slot, the low 16 bits of the four 8.8 inverse matrix terms and the
// saturated x and unsaturated y foot corrections. csr channel: register
// writes (object scale, minimum scale, foot line), always ready, to be
// issued while idle. A request runs from accept to rsp_tvalid through the
// chain of three bit-per-stage dividers (matrix terms, foot row, foot
// column) plus the input, multiply and output registers.
// throughput: one request per cycle while the output does not stall; every stage holds one request.
// stall: all stages advance together whenever the output register is empty
// or being taken; while rsp_tready is low with a result waiting, req_tready
// drops and every stage holds, nothing is lost or repeated.
// reset: clears all stage valid bits and loads object scale 100, minimum
// scale 10 and foot line 32.
`default_nettype none
module sprite_shadow_affine_setup (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [55:0]  req_tdata,   // slot_index, width_pct, height_pct, shear_horiz, shear_vert
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata,   // slot_out, term_a, term_b, term_c, term_d, offset_x, offset_y
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [1:0]   csr_index,
   input  wire  [8:0]   csr_data
);

   logic [8:0] object_scale_ff;
   logic [6:0] min_scale_ff;
   logic [6:0] foot_line_ff;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         object_scale_ff <= 9'd100;
         min_scale_ff    <= 7'd10;
         foot_line_ff    <= 7'd32;
      end else if (csr_valid) begin
         case (csr_index)
            ssa_pkg::CSR_OBJECT_SCALE: object_scale_ff <= csr_data;
            ssa_pkg::CSR_MIN_SCALE:    min_scale_ff    <= csr_data[6:0];
            ssa_pkg::CSR_FOOT_LINE:    foot_line_ff    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   logic [8:0] scale_eff;
   logic [6:0] mn_eff;
   assign scale_eff = (object_scale_ff == '0) ? 9'd1 : object_scale_ff;
   assign mn_eff    = (min_scale_ff == '0) ? 7'd1 : min_scale_ff;

   // stage a: scale clamp
   logic signed [10:0] w_raw, h_raw;
   logic signed [11:0] mn12;
   logic signed [10:0] w_cl, h_cl;
   assign w_raw = req_tdata[15:5];
   assign h_raw = req_tdata[26:16];
   assign mn12  = $signed({5'b0, mn_eff});

   always_comb begin
      w_cl = w_raw;
      h_cl = h_raw;
      if ((12'(w_raw) > -mn12) && (12'(w_raw) < mn12))
         w_cl = w_raw[10] ? 11'(-mn12) : 11'(mn12);
      if ((12'(h_raw) > -mn12) && (12'(h_raw) < mn12))
         h_cl = h_raw[10] ? 11'(-mn12) : 11'(mn12);
   end

   logic               a_vld_ff;
   logic [4:0]         a_slot_ff;
   logic signed [10:0] a_w_ff, a_h_ff, a_sh_ff, a_sv_ff;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_slot_ff <= req_tdata[4:0];
         a_w_ff    <= w_cl;
         a_h_ff    <= h_cl;
         a_sh_ff   <= req_tdata[37:27];
         a_sv_ff   <= req_tdata[48:38];
      end
   end

   // stage b: divisor and dividend products
   logic signed [20:0] pw_full, ph_full;
   logic signed [25:0] nb_full, nc_full;
   logic        [16:0] den_full;
   assign pw_full  = a_w_ff * $signed({1'b0, scale_eff});
   assign ph_full  = a_h_ff * $signed({1'b0, scale_eff});
   assign nb_full  = a_sh_ff * $signed(16'(ssa_pkg::SHEAR_MUL));
   assign nc_full  = a_sv_ff * $signed(16'(ssa_pkg::SHEAR_MUL));
   assign den_full = scale_eff * 7'(ssa_pkg::PERCENT);

   logic        b_vld_ff;
   logic [4:0]  b_slot_ff;
   logic [19:0] b_pw_ff, b_ph_ff, b_den_ff;
   logic [25:0] b_nb_ff, b_nc_ff;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (adv) b_vld_ff <= a_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_slot_ff <= a_slot_ff;
         b_pw_ff   <= pw_full[19:0];
         b_ph_ff   <= ph_full[19:0];
         b_den_ff  <= {3'b0, den_full};
         b_nb_ff   <= nb_full;
         b_nc_ff   <= nc_full;
      end
   end

   // matrix terms
   ssa_pkg::stage_ctl_type d1_ctl, d2_ctl, d3_ctl;
   logic                   d1_vld, d2_vld, d3_vld;
   logic [3:0][25:0]       d1_num, d1_quo;
   logic [3:0][19:0]       d1_den;
   logic [4:0]             d1_slot;

   assign d1_ctl = '{en: adv, valid: b_vld_ff};
   assign d1_num = {26'(ssa_pkg::UNITY_NUM), b_nc_ff, b_nb_ff, 26'(ssa_pkg::UNITY_NUM)};
   assign d1_den = {b_ph_ff, b_den_ff, b_den_ff, b_pw_ff};

   ssa_pipe_div #(.LANES(4), .NW(25), .DW(19), .SW(5)) u_div_terms (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (d1_ctl),
      .in_num   (d1_num),
      .in_den   (d1_den),
      .in_side  (b_slot_ff),
      .out_valid(d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_slot)
   );

   // foot row: side = slot, terms a..d, full pa, full pb
   logic [111:0]    d2_side_i, d2_side_o;
   logic [0:0][15:0] d2_num, d2_quo;
   logic [0:0][22:0] d2_den;

   assign d2_ctl    = '{en: adv, valid: d1_vld};
   assign d2_num[0] = {1'b0, foot_line_ff, 8'b0};
   assign d2_den[0] = d1_quo[3][22:0];
   assign d2_side_i = {d1_quo[1][19:0], d1_quo[0][22:0], d1_quo[3][15:0], d1_quo[2][15:0],
                       d1_quo[1][15:0], d1_quo[0][15:0], d1_slot};

   ssa_pipe_div #(.LANES(1), .NW(15), .DW(22), .SW(112)) u_div_foot_y (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (d2_ctl),
      .in_num   (d2_num),
      .in_den   (d2_den),
      .in_side  (d2_side_i),
      .out_valid(d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_side_o)
   );

   // stage m: pb times foot row
   logic signed [35:0] prod_full;
   assign prod_full = $signed(d2_side_o[111:92]) * $signed(d2_quo[0]);

   logic        m_vld_ff;
   logic [34:0] m_prod_ff;
   logic [22:0] m_pa_ff;
   logic [84:0] m_side_ff;

   always_ff @(posedge clock) begin
      if (reset) m_vld_ff <= 1'b0;
      else if (adv) m_vld_ff <= d2_vld;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_prod_ff <= prod_full[34:0];
         m_pa_ff   <= d2_side_o[91:69];
         m_side_ff <= {d2_quo[0], d2_side_o[68:0]};
      end
   end

   // foot column
   logic [0:0][34:0] d3_num, d3_quo;
   logic [0:0][22:0] d3_den;
   logic [84:0]      d3_side;

   assign d3_ctl    = '{en: adv, valid: m_vld_ff};
   assign d3_num[0] = m_prod_ff;
   assign d3_den[0] = m_pa_ff;

   ssa_pipe_div #(.LANES(1), .NW(34), .DW(22), .SW(85)) u_div_foot_x (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (d3_ctl),
      .in_num   (d3_num),
      .in_den   (d3_den),
      .in_side  (m_side_ff),
      .out_valid(d3_vld),
      .out_quo  (d3_quo),
      .out_side (d3_side)
   );

   // output register
   logic signed [34:0] qx;
   logic        [15:0] off_x, off_y;
   assign qx = d3_quo[0];

   always_comb begin
      if (qx > 35'sd32767)       off_x = 16'h7FFF;
      else if (qx < -35'sd32768) off_x = 16'h8000;
      else                       off_x = qx[15:0];
   end
   assign off_y = {9'b0, foot_line_ff} - d3_side[84:69];

   logic         rsp_vld_ff;
   logic [103:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (adv) rsp_vld_ff <= d3_vld;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= {3'b0, off_y, off_x, d3_side[68:0]};
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !adv) |=> a_vld_ff)
      else $error("stage a valid dropped during stall");

   m_hold : assert property (@(posedge clock) disable iff (reset)
      (!adv) |=> ($stable(m_vld_ff) && $stable(m_prod_ff)))
      else $error("multiply stage moved during stall");

   accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> a_vld_ff)
      else $error("accepted request not captured");

endmodule
`default_nettype wire

// File: bench/tb_sprite_shadow_affine_setup.sv
`timescale 1ns / 1ps
module tb_sprite_shadow_affine_setup;

   typedef struct packed {
      logic signed [10:0] shear_vert;
      logic signed [10:0] shear_horiz;
      logic signed [10:0] height_pct;
      logic signed [10:0] width_pct;
      logic [4:0]         slot_index;
   } shadow_req_type;

   typedef struct packed {
      logic signed [15:0] offset_y;
      logic signed [15:0] offset_x;
      logic [15:0]        term_d;
      logic [15:0]        term_c;
      logic [15:0]        term_b;
      logic [15:0]        term_a;
      logic [4:0]         slot_out;
   } shadow_rsp_type;

   localparam int LATENCY = 84;
   localparam int WATCHDOG_LIMIT = 2000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [8:0]   csr_data;

   sprite_shadow_affine_setup uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   shadow_req_type pending_reqs[$];
   shadow_rsp_type expected_terms[$];
   logic [8:0]  cur_object_scale;
   logic [6:0]  cur_min_scale;
   logic [6:0]  cur_foot_line;
   int          errors;
   int          idle_cycles;
   bit          idling_on;
   bit          timed_out;
   bit          req_acc;
   int          req_gap;
   int          rsp_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_scale(longint s, longint mn);
      if (s > -mn && s < mn)
         return (s < 0) ? -mn : mn;
      return s;
   endfunction

   function automatic logic [15:0] sat16(longint v);
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[15:0];
   endfunction

   function automatic shadow_rsp_type compute_affine(shadow_req_type r);
      shadow_rsp_type o;
      longint scale, mn, foot, w, h, sh, sv, pa, pb, pc, pd, fy, fx;
      scale = cur_object_scale;
      mn = cur_min_scale;
      foot = cur_foot_line;
      if (scale == 0)
         scale = 1;
      if (mn == 0)
         mn = 1;
      w = clamp_scale(longint'(r.width_pct), mn);
      h = clamp_scale(longint'(r.height_pct), mn);
      sh = r.shear_horiz;
      sv = r.shear_vert;
      pa = longint'(ssa_pkg::UNITY_NUM) / (w * scale);
      pd = longint'(ssa_pkg::UNITY_NUM) / (h * scale);
      pb = (sh * longint'(ssa_pkg::SHEAR_MUL)) / (longint'(ssa_pkg::PERCENT) * scale);
      pc = (sv * longint'(ssa_pkg::SHEAR_MUL)) / (longint'(ssa_pkg::PERCENT) * scale);
      fy = (pd != 0) ? (256 * foot) / pd : foot;
      fx = (pa != 0) ? (-(pb * fy)) / pa : 0;
      o.slot_out = r.slot_index;
      o.term_a = pa[15:0];
      o.term_b = pb[15:0];
      o.term_c = pc[15:0];
      o.term_d = pd[15:0];
      o.offset_x = sat16(-fx);
      o.offset_y = sat16(foot - fy);
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && !req_acc) begin
            req_tvalid <= 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 19) == 0) begin
            req_gap = $urandom_range(0, 13);
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {7'b0, pending_reqs[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 19) == 0) begin
            rsp_gap = $urandom_range(0, 13);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // prediction at accept, monitor and watchdog
   always @(posedge clock) begin
      shadow_rsp_type exp_r;
      shadow_rsp_type got;
      req_acc = req_tvalid && req_tready;
      if (!reset) begin
         if (req_acc) begin
            expected_terms.push_back(compute_affine(req_tdata[48:0]));
            void'(pending_reqs.pop_front());
         end
         if (req_acc || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[100:0];
            if (expected_terms.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               errors++;
            end else begin
               exp_r = expected_terms.pop_front();
               if (got.slot_out !== exp_r.slot_out) begin
                  $error("slot_out exp %0d got %0d", exp_r.slot_out, got.slot_out);
                  errors++;
               end
               if (got.term_a !== exp_r.term_a) begin
                  $error("term_a exp %h got %h", exp_r.term_a, got.term_a);
                  errors++;
               end
               if (got.term_b !== exp_r.term_b) begin
                  $error("term_b exp %h got %h", exp_r.term_b, got.term_b);
                  errors++;
               end
               if (got.term_c !== exp_r.term_c) begin
                  $error("term_c exp %h got %h", exp_r.term_c, got.term_c);
                  errors++;
               end
               if (got.term_d !== exp_r.term_d) begin
                  $error("term_d exp %h got %h", exp_r.term_d, got.term_d);
                  errors++;
               end
               if (got.offset_x !== exp_r.offset_x) begin
                  $error("offset_x exp %0d got %0d", exp_r.offset_x, got.offset_x);
                  errors++;
               end
               if (got.offset_y !== exp_r.offset_y) begin
                  $error("offset_y exp %0d got %0d", exp_r.offset_y, got.offset_y);
                  errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT)
            timed_out = 1'b1;
      end
   end

   function automatic logic [10:0] rand_pct(int mn);
      int k;
      k = $urandom_range(0, 9);
      if (k < 3)
         return 11'($signed($urandom_range(0, 2 * mn + 2)) - mn - 1);
      if (k == 3)
         return 11'($urandom);
      return 11'($signed($urandom_range(0, 2000)) - 1000);
   endfunction

   function automatic shadow_req_type rand_req(int mn);
      shadow_req_type r;
      r.slot_index = 5'($urandom);
      r.width_pct = rand_pct(mn);
      r.height_pct = rand_pct(mn);
      r.shear_horiz = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                      : 11'($signed($urandom_range(0, 2000)) - 1000);
      r.shear_vert = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                     : 11'($signed($urandom_range(0, 2000)) - 1000);
      return r;
   endfunction

   function automatic shadow_req_type make_req(int s, int w, int h, int sh, int sv);
      shadow_req_type r;
      r.slot_index = 5'(s);
      r.width_pct = 11'(w);
      r.height_pct = 11'(h);
      r.shear_horiz = 11'(sh);
      r.shear_vert = 11'(sv);
      return r;
   endfunction

   task automatic wait_drained();
      while ((pending_reqs.size() > 0 || expected_terms.size() > 0) && !timed_out)
         @(posedge clock);
   endtask

   task automatic csr_write(ssa_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 9'(value);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         ssa_pkg::CSR_OBJECT_SCALE: cur_object_scale = 9'(value);
         ssa_pkg::CSR_MIN_SCALE:    cur_min_scale = 7'(value);
         ssa_pkg::CSR_FOOT_LINE:    cur_foot_line = 7'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int os, int mn, int fl, int count);
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      csr_write(ssa_pkg::CSR_OBJECT_SCALE, os);
      csr_write(ssa_pkg::CSR_MIN_SCALE, mn);
      csr_write(ssa_pkg::CSR_FOOT_LINE, fl);
      for (int i = 0; i < count; i++)
         pending_reqs.push_back(rand_req(mn));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = ssa_pkg::CSR_OBJECT_SCALE;
      csr_data = '0;
      errors = 0;
      idle_cycles = 0;
      idling_on = 1'b1;
      timed_out = 1'b0;
      req_acc = 1'b0;
      rsp_gap = 0;
      cur_object_scale = 100;
      cur_min_scale = 10;
      cur_foot_line = 32;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings
      pending_reqs.push_back(make_req(0, 100, 100, 0, 0));
      pending_reqs.push_back(make_req(31, -1000, 1000, -1000, 1000));
      pending_reqs.push_back(make_req(5, 0, 0, 1000, -1000));
      pending_reqs.push_back(make_req(7, 9, -9, 0, 0));
      pending_reqs.push_back(make_req(8, -10, 10, 1, -1));
      pending_reqs.push_back(make_req(9, 1023, -1024, 1023, -1024));
      pending_reqs.push_back(make_req(10, -1, 1, 500, -500));
      pending_reqs.push_back(make_req(21, 1000, 1000, 1000, 1000));
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      // zero object scale and zero minimum scale
      csr_write(ssa_pkg::CSR_OBJECT_SCALE, 0);
      csr_write(ssa_pkg::CSR_MIN_SCALE, 0);
      csr_write(ssa_pkg::CSR_FOOT_LINE, 127);
      pending_reqs.push_back(make_req(1, 0, 0, 1000, -1000));
      pending_reqs.push_back(make_req(2, 1, -1, -1000, 1000));
      pending_reqs.push_back(make_req(3, -1024, 1023, 0, 0));
      pending_reqs.push_back(make_req(4, 2, 3, 7, -7));
      // large scale where small shear terms go to zero
      run_phase(400, 100, 0, 0);
      pending_reqs.push_back(make_req(11, 1000, 1000, 0, 0));
      pending_reqs.push_back(make_req(12, -99, 99, 5, 5));
      pending_reqs.push_back(make_req(13, 0, -100, 1, 1));
      pending_reqs.push_back(make_req(14, 1000, -1000, -1000, 1000));
      pending_reqs.push_back(make_req(15, 511, 200, 300, 300));

      run_phase(511, 127, 127, 150);
      run_phase(1, 1, 0, 250);
      run_phase(100, 10, 32, 300);
      run_phase(400, 100, 127, 200);
      run_phase($urandom_range(1, 400), $urandom_range(1, 100), $urandom_range(0, 127), 300);
      // sender holds off until all results are back
      wait_drained();
      run_phase(3, 50, 64, 250);
      wait_drained();
      idling_on = 1'b0;
      run_phase(250, 5, 100, 200);
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      if (timed_out || errors != 0)
         $display("simulation failed");
      else
         $display("simulation ok");
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("simulation failed");
      $finish;
   end

endmodule
